/* rtl/sktbl_pkg.sv */
// Shared types, constants and helpers for the sorted keyed position table.
// Used by the top level and the sequencer; depends on nothing.
`timescale 1ns / 1ps

package sktbl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W      = 6;
    localparam int HELD_W      = 7;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [HELD_W-1:0] held_t;

    // Edge sentinel ids
    localparam logic [31:0] ID_MIN = 32'h8000_0000;
    localparam logic [31:0] ID_MAX = 32'h7fff_ffff;

    // Request modes
    localparam logic [3:0] MODE_SET_HEAD = 4'd0;
    localparam logic [3:0] MODE_SET_TAIL = 4'd1;
    localparam logic [3:0] MODE_INSERT   = 4'd2;
    localparam logic [3:0] MODE_UPDATE   = 4'd3;
    localparam logic [3:0] MODE_REMOVE   = 4'd4;
    localparam logic [3:0] MODE_FIND     = 4'd5;
    localparam logic [3:0] MODE_ABOVE    = 4'd6;
    localparam logic [3:0] MODE_BELOW    = 4'd7;
    localparam logic [3:0] MODE_SORT     = 4'd8;
    localparam logic [3:0] MODE_CLEAR    = 4'd9;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [7:0]  etype;
        logic [31:0] eid;
        logic [31:0] epos;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [3:0]  mode;
        logic [7:0]  etype;
        logic [31:0] eid;
        logic [31:0] epos;
        logic        ex_en;
        logic [5:0]  ex_slot;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        slot_t      slot;
        entry_t     entry;
    } res_t;

    typedef struct packed {
        logic   valid;
        res_t   res;
        held_t  held;
    } done_t;

    typedef struct packed {
        logic   we;
        addr_t  waddr;
        entry_t wdata;
        logic   re;
        addr_t  raddr;
    } ram_req_t;

    // Signed compare of two 16.16 positions
    function automatic logic pos_less(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

/* rtl/sorted_keyed_position_table.sv */
// Top level of the sorted keyed position table: ports, configuration register,
// output register and checks. Depends on sktbl_pkg, sktbl_ram and sktbl_ctrl.
`timescale 1ns / 1ps

// The table holds up to 64 entries in one RAM and serves one request at a time;
// s_ready is high only while the sequencer is idle. Each entry visited passes
// through the single RAM read port, a read and then the compare. Find, update
// and the nearest searches scan the entries, remove of an entry that is present
// scans for it and closes its gap, set head shifts every entry up, set tail
// writes the new entry at the end, and insert scans for the key, closes its gap,
// scans for the place and opens one. Sort has insertion sort, head and tail edge
// passes. Clear, unused modes, requests that meet an empty table and set head or
// set tail on a full table go straight to the result. A finished result waits in
// the output register and the next request is taken meanwhile; while that
// register is stalled the sequencer keeps its next result and takes no further
// request. The edge type code may be written at any time the block is idle;
// cfg_ready is always high.
module sorted_keyed_position_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_mode,
    input  logic [7:0]  s_entry_type,
    input  logic [31:0] s_entry_id,
    input  logic [31:0] s_entry_position,
    input  logic        s_exclude_enable,
    input  logic [5:0]  s_exclude_slot,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_edge_type_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [5:0]  m_found_slot,
    output logic [7:0]  m_found_type,
    output logic [31:0] m_found_id,
    output logic [31:0] m_found_position,
    output logic [6:0]  m_entries_held
);

    logic [7:0]          edge_type_reg;
    sktbl_pkg::req_t     req;
    sktbl_pkg::ram_req_t ram;
    sktbl_pkg::entry_t   rdata;
    sktbl_pkg::done_t    done;
    logic                out_free;
    logic                m_valid_reg;
    sktbl_pkg::res_t     m_res_reg;
    sktbl_pkg::held_t    m_held_reg;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_type_reg <= 8'd0;
        end else if (cfg_valid) begin
            edge_type_reg <= cfg_edge_type_code;
        end
    end

    assign req = '{mode: s_mode, etype: s_entry_type, eid: s_entry_id,
                   epos: s_entry_position, ex_en: s_exclude_enable,
                   ex_slot: s_exclude_slot};

    sktbl_ram #(
        .WIDTH (sktbl_pkg::ENTRY_W),
        .DEPTH (sktbl_pkg::TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .re    (ram.re),
        .raddr (ram.raddr),
        .rdata (rdata)
    );

    sktbl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req       (req),
        .req_ready (s_ready),
        .edge_code (edge_type_reg),
        .ram       (ram),
        .rdata     (rdata),
        .done      (done),
        .out_free  (out_free)
    );

    // Output register
    assign out_free = !m_valid_reg || m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= done.valid;
        end
        if (out_free && done.valid) begin
            m_res_reg  <= done.res;
            m_held_reg <= done.held;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_res_reg.status;
    assign m_found_slot     = m_res_reg.slot;
    assign m_found_type     = m_res_reg.entry.etype;
    assign m_found_id       = m_res_reg.entry.eid;
    assign m_found_position = m_res_reg.entry.epos;
    assign m_entries_held   = m_held_reg;

`ifndef ASSERT_OFF
    // A request once taken makes the sequencer busy.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while the previous one was still running");

    // The table never reports more entries than it can hold.
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entries_held <= 7'(sktbl_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    // A full table returns no entry.
    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == sktbl_pkg::ST_FULL |->
            m_found_slot == 6'd0 && m_found_id == 32'd0 && m_found_type == 8'd0)
        else $error("full status with an entry attached");

    // A stalled result stays as it is until it is taken.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found_id) && $stable(m_status))
        else $error("stalled result changed");
`endif

endmodule

/* rtl/sktbl_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module sktbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/sktbl_ctrl.sv */
// Sequencer of the table: scans, shifts and sorts the entries held in the RAM.
// Depends on sktbl_pkg; drives one sktbl_ram instance through the top level.
`timescale 1ns / 1ps

module sktbl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    input  sktbl_pkg::req_t     req,
    output logic                req_ready,
    input  logic [7:0]          edge_code,
    output sktbl_pkg::ram_req_t ram,
    input  sktbl_pkg::entry_t   rdata,
    output sktbl_pkg::done_t    done,
    input  logic                out_free
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FWD_RD  = 4'd1;
    localparam logic [3:0] S_FWD_EV  = 4'd2;
    localparam logic [3:0] S_BWD_RD  = 4'd3;
    localparam logic [3:0] S_BWD_EV  = 4'd4;
    localparam logic [3:0] S_UP_RD   = 4'd5;
    localparam logic [3:0] S_UP_EV   = 4'd6;
    localparam logic [3:0] S_DN_RD   = 4'd7;
    localparam logic [3:0] S_DN_EV   = 4'd8;
    localparam logic [3:0] S_SORT_RD = 4'd9;
    localparam logic [3:0] S_SORT_EV = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    localparam logic [2:0] PH_KEY  = 3'd0;
    localparam logic [2:0] PH_POS  = 3'd1;
    localparam logic [2:0] PH_NEAR = 3'd2;
    localparam logic [2:0] PH_SORT = 3'd3;
    localparam logic [2:0] PH_HEAD = 3'd4;
    localparam logic [2:0] PH_TAIL = 3'd5;

    logic [3:0]          state_reg, state_next;
    logic [2:0]          phase_reg, phase_next;
    sktbl_pkg::req_t     req_reg, req_next;
    sktbl_pkg::cnt_t     cnt_reg, cnt_next;
    sktbl_pkg::cnt_t     idx_reg, idx_next;
    sktbl_pkg::cnt_t     lo_reg, lo_next;
    sktbl_pkg::cnt_t     sort_i_reg, sort_i_next;
    sktbl_pkg::entry_t   hold_reg, hold_next;
    logic                up_sort_reg, up_sort_next;
    logic                dn_tail_reg, dn_tail_next;
    sktbl_pkg::res_t     res_reg, res_next;

    sktbl_pkg::cnt_t     idx_m1, idx_p1, place_cnt;
    logic                up_done, dn_done, head_start, tail_start, place_start;
    logic                match_fwd, match_bwd, is_last;
    sktbl_pkg::entry_t   upd_entry;

    assign req_ready = (state_reg == S_IDLE);
    assign idx_m1    = idx_reg - sktbl_pkg::cnt_t'(1);
    assign idx_p1    = idx_reg + sktbl_pkg::cnt_t'(1);
    assign is_last   = (idx_p1 == cnt_reg);
    assign upd_entry = '{etype: rdata.etype, eid: rdata.eid, epos: req_reg.epos};

    // Scan predicates on the entry just read
    always_comb begin
        unique case (phase_reg)
            PH_KEY:  match_fwd = (rdata.etype == req_reg.etype) && (rdata.eid == req_reg.eid);
            PH_POS:  match_fwd = !sktbl_pkg::pos_less(rdata.epos, req_reg.epos);
            PH_NEAR: match_fwd = !(req_reg.ex_en && idx_reg == sktbl_pkg::cnt_t'(req_reg.ex_slot))
                                 && !sktbl_pkg::pos_less(rdata.epos, req_reg.epos);
            PH_HEAD: match_fwd = (rdata.etype == edge_code) && rdata.eid[31];
            PH_TAIL: match_fwd = (rdata.etype == edge_code) && !rdata.eid[31]
                                 && (rdata.eid != 32'd0);
            default: match_fwd = 1'b0;
        endcase
        match_bwd = !(req_reg.ex_en && idx_m1 == sktbl_pkg::cnt_t'(req_reg.ex_slot))
                    && !sktbl_pkg::pos_less(req_reg.epos, rdata.epos);
    end

    // Next-state logic of the sequencer
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        lo_next      = lo_reg;
        sort_i_next  = sort_i_reg;
        hold_next    = hold_reg;
        up_sort_next = up_sort_reg;
        dn_tail_next = dn_tail_reg;
        res_next     = res_reg;
        ram          = '0;
        up_done      = 1'b0;
        dn_done      = 1'b0;
        head_start   = 1'b0;
        tail_start   = 1'b0;
        place_start  = 1'b0;
        place_cnt    = cnt_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    req_next = req;
                    res_next = '0;
                    unique case (req.mode)
                        sktbl_pkg::MODE_SET_HEAD, sktbl_pkg::MODE_SET_TAIL: begin
                            if (cnt_reg == sktbl_pkg::cnt_t'(sktbl_pkg::TABLE_DEPTH)) begin
                                res_next.status = sktbl_pkg::ST_FULL;
                                state_next      = S_DONE;
                            end else begin
                                hold_next.etype = edge_code;
                                hold_next.eid   = (req.mode == sktbl_pkg::MODE_SET_HEAD) ?
                                                  sktbl_pkg::ID_MIN : sktbl_pkg::ID_MAX;
                                hold_next.epos  = req.epos;
                                lo_next         = (req.mode == sktbl_pkg::MODE_SET_HEAD) ?
                                                  '0 : cnt_reg;
                                idx_next        = cnt_reg;
                                up_sort_next    = 1'b0;
                                res_next.status = sktbl_pkg::ST_OK;
                                res_next.slot   = (req.mode == sktbl_pkg::MODE_SET_HEAD) ?
                                                  '0 : sktbl_pkg::slot_t'(cnt_reg);
                                res_next.entry  = '{etype: edge_code, eid: hold_next.eid,
                                                    epos: req.epos};
                                state_next      = S_UP_RD;
                            end
                        end
                        sktbl_pkg::MODE_INSERT, sktbl_pkg::MODE_UPDATE,
                        sktbl_pkg::MODE_REMOVE, sktbl_pkg::MODE_FIND,
                        sktbl_pkg::MODE_ABOVE: begin
                            if (cnt_reg == '0) begin
                                res_next.status = sktbl_pkg::ST_MISS;
                                state_next      = S_DONE;
                            end else begin
                                idx_next   = '0;
                                phase_next = (req.mode == sktbl_pkg::MODE_ABOVE) ?
                                             PH_NEAR : PH_KEY;
                                state_next = S_FWD_RD;
                            end
                        end
                        sktbl_pkg::MODE_BELOW: begin
                            if (cnt_reg == '0) begin
                                res_next.status = sktbl_pkg::ST_MISS;
                                state_next      = S_DONE;
                            end else begin
                                idx_next   = cnt_reg;
                                state_next = S_BWD_RD;
                            end
                        end
                        sktbl_pkg::MODE_SORT: begin
                            if (cnt_reg == '0) begin
                                state_next = S_DONE;
                            end else if (cnt_reg == sktbl_pkg::cnt_t'(1)) begin
                                head_start = 1'b1;
                            end else begin
                                sort_i_next = sktbl_pkg::cnt_t'(1);
                                phase_next  = PH_SORT;
                                state_next  = S_SORT_RD;
                            end
                        end
                        sktbl_pkg::MODE_CLEAR: begin
                            cnt_next   = '0;
                            state_next = S_DONE;
                        end
                        default: begin
                            res_next.status = sktbl_pkg::ST_MISS;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_FWD_RD: begin
                ram.re     = 1'b1;
                ram.raddr  = idx_reg[sktbl_pkg::ADDR_W-1:0];
                state_next = S_FWD_EV;
            end
            S_FWD_EV: begin
                if (match_fwd) begin
                    unique case (phase_reg)
                        PH_KEY: begin
                            res_next.status = sktbl_pkg::ST_OK;
                            res_next.slot   = sktbl_pkg::slot_t'(idx_reg);
                            res_next.entry  = rdata;
                            if (req_reg.mode == sktbl_pkg::MODE_UPDATE) begin
                                ram.we         = 1'b1;
                                ram.waddr      = idx_reg[sktbl_pkg::ADDR_W-1:0];
                                ram.wdata      = upd_entry;
                                res_next.entry = upd_entry;
                                state_next     = S_DONE;
                            end else if (req_reg.mode == sktbl_pkg::MODE_FIND) begin
                                state_next = S_DONE;
                            end else begin
                                dn_tail_next = 1'b0;
                                state_next   = S_DN_RD;
                            end
                        end
                        PH_POS: begin
                            hold_next       = '{etype: req_reg.etype, eid: req_reg.eid,
                                                epos: req_reg.epos};
                            lo_next         = idx_reg;
                            idx_next        = cnt_reg;
                            up_sort_next    = 1'b0;
                            res_next.status = sktbl_pkg::ST_OK;
                            res_next.slot   = sktbl_pkg::slot_t'(idx_reg);
                            res_next.entry  = hold_next;
                            state_next      = S_UP_RD;
                        end
                        PH_NEAR: begin
                            res_next.status = sktbl_pkg::ST_OK;
                            res_next.slot   = sktbl_pkg::slot_t'(idx_reg);
                            res_next.entry  = rdata;
                            state_next      = S_DONE;
                        end
                        PH_HEAD: begin
                            hold_next    = rdata;
                            lo_next      = '0;
                            up_sort_next = 1'b0;
                            state_next   = S_UP_RD;
                        end
                        PH_TAIL: begin
                            hold_next    = rdata;
                            dn_tail_next = 1'b1;
                            state_next   = S_DN_RD;
                        end
                        default: state_next = S_DONE;
                    endcase
                end else if (is_last) begin
                    unique case (phase_reg)
                        PH_KEY: begin
                            if (req_reg.mode == sktbl_pkg::MODE_INSERT) begin
                                place_start = 1'b1;
                            end else begin
                                res_next.status = sktbl_pkg::ST_MISS;
                                state_next      = S_DONE;
                            end
                        end
                        PH_NEAR: begin
                            res_next.status = sktbl_pkg::ST_MISS;
                            res_next.slot   = sktbl_pkg::slot_t'(idx_reg);
                            res_next.entry  = rdata;
                            state_next      = S_DONE;
                        end
                        PH_HEAD: tail_start = 1'b1;
                        PH_POS: begin
                            res_next.status = sktbl_pkg::ST_MISS;
                            state_next      = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end else begin
                    idx_next   = idx_p1;
                    state_next = S_FWD_RD;
                end
            end
            S_BWD_RD: begin
                ram.re     = 1'b1;
                ram.raddr  = idx_m1[sktbl_pkg::ADDR_W-1:0];
                state_next = S_BWD_EV;
            end
            S_BWD_EV: begin
                if (match_bwd || idx_m1 == '0) begin
                    res_next.status = match_bwd ? sktbl_pkg::ST_OK : sktbl_pkg::ST_MISS;
                    res_next.slot   = sktbl_pkg::slot_t'(idx_m1);
                    res_next.entry  = rdata;
                    state_next      = S_DONE;
                end else begin
                    idx_next   = idx_m1;
                    state_next = S_BWD_RD;
                end
            end
            // Shift entries up by one slot, then drop the held entry into the gap
            S_UP_RD: begin
                if (idx_reg == lo_reg) begin
                    ram.we    = 1'b1;
                    ram.waddr = idx_reg[sktbl_pkg::ADDR_W-1:0];
                    ram.wdata = hold_reg;
                    up_done   = 1'b1;
                end else begin
                    ram.re     = 1'b1;
                    ram.raddr  = idx_m1[sktbl_pkg::ADDR_W-1:0];
                    state_next = S_UP_EV;
                end
            end
            S_UP_EV: begin
                ram.we    = 1'b1;
                ram.waddr = idx_reg[sktbl_pkg::ADDR_W-1:0];
                if (up_sort_reg && !sktbl_pkg::pos_less(hold_reg.epos, rdata.epos)) begin
                    ram.wdata = hold_reg;
                    up_done   = 1'b1;
                end else begin
                    ram.wdata  = rdata;
                    idx_next   = idx_m1;
                    state_next = S_UP_RD;
                end
            end
            // Shift entries down by one slot, closing the gap at the start slot
            S_DN_RD: begin
                if (idx_p1 >= cnt_reg) begin
                    ram.we    = dn_tail_reg;
                    ram.waddr = idx_reg[sktbl_pkg::ADDR_W-1:0];
                    ram.wdata = hold_reg;
                    dn_done   = 1'b1;
                end else begin
                    ram.re     = 1'b1;
                    ram.raddr  = idx_p1[sktbl_pkg::ADDR_W-1:0];
                    state_next = S_DN_EV;
                end
            end
            S_DN_EV: begin
                ram.we     = 1'b1;
                ram.waddr  = idx_reg[sktbl_pkg::ADDR_W-1:0];
                ram.wdata  = rdata;
                idx_next   = idx_p1;
                state_next = S_DN_RD;
            end
            // Insertion sort: fetch the next entry to place
            S_SORT_RD: begin
                ram.re     = 1'b1;
                ram.raddr  = sort_i_reg[sktbl_pkg::ADDR_W-1:0];
                state_next = S_SORT_EV;
            end
            S_SORT_EV: begin
                hold_next    = rdata;
                idx_next     = sort_i_reg;
                lo_next      = '0;
                up_sort_next = 1'b1;
                state_next   = S_UP_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // What follows a finished upward shift
        if (up_done) begin
            if (req_reg.mode == sktbl_pkg::MODE_SORT) begin
                if (phase_reg == PH_SORT) begin
                    sort_i_next = sort_i_reg + sktbl_pkg::cnt_t'(1);
                    if (sort_i_next >= cnt_reg) begin
                        head_start = 1'b1;
                    end else begin
                        state_next = S_SORT_RD;
                    end
                end else begin
                    tail_start = 1'b1;
                end
            end else begin
                cnt_next   = cnt_reg + sktbl_pkg::cnt_t'(1);
                state_next = S_DONE;
            end
        end

        // What follows a finished downward shift
        if (dn_done) begin
            if (req_reg.mode == sktbl_pkg::MODE_SORT) begin
                res_next   = '0;
                state_next = S_DONE;
            end else begin
                cnt_next = cnt_reg - sktbl_pkg::cnt_t'(1);
                if (req_reg.mode == sktbl_pkg::MODE_INSERT) begin
                    place_start = 1'b1;
                    place_cnt   = cnt_next;
                end else begin
                    state_next = S_DONE;
                end
            end
        end

        // Start of the edge passes of a sort
        if (head_start) begin
            idx_next   = '0;
            phase_next = PH_HEAD;
            state_next = S_FWD_RD;
        end
        if (tail_start) begin
            idx_next   = '0;
            phase_next = PH_TAIL;
            state_next = S_FWD_RD;
        end

        // Start of the placement pass of an insert
        if (place_start) begin
            res_next = '0;
            if (place_cnt == sktbl_pkg::cnt_t'(sktbl_pkg::TABLE_DEPTH)) begin
                res_next.status = sktbl_pkg::ST_FULL;
                state_next      = S_DONE;
            end else if (place_cnt == '0) begin
                res_next.status = sktbl_pkg::ST_MISS;
                state_next      = S_DONE;
            end else begin
                idx_next   = '0;
                phase_next = PH_POS;
                state_next = S_FWD_RD;
            end
        end
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        phase_reg   <= phase_next;
        req_reg     <= req_next;
        idx_reg     <= idx_next;
        lo_reg      <= lo_next;
        sort_i_reg  <= sort_i_next;
        hold_reg    <= hold_next;
        up_sort_reg <= up_sort_next;
        dn_tail_reg <= dn_tail_next;
        res_reg     <= res_next;
    end

    // Finished result towards the output register
    assign done.valid = (state_reg == S_DONE);
    assign done.res   = res_reg;
    assign done.held  = sktbl_pkg::held_t'(cnt_reg);

endmodule
